// ===== rtl/core/jtdm_pkg.sv =====
// ----------------------------------------------------------------------------
// jtdm_pkg
// shared widths, register indexes, state types and helpers of the tank drive
// mixer
// ----------------------------------------------------------------------------
package jtdm_pkg;

	localparam int PULSE_BITS = 16;
	localparam int DUTY_BITS  = 8;

	// quotient holds up to twice the span, coordinate is quotient minus span
	localparam int QUOT_W  = DUTY_BITS + 1;
	localparam int COORD_W = QUOT_W + 1;
	localparam int SUM_W   = COORD_W + 1;
	localparam int PROD_W  = PULSE_BITS + QUOT_W;
	localparam int CNT_W   = $clog2(PROD_W + 1);

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [PULSE_BITS-1:0] PULSE_MIN_RST = PULSE_BITS'(1000);
	localparam logic [PULSE_BITS-1:0] PULSE_MAX_RST = PULSE_BITS'(2000);
	localparam logic [DUTY_BITS-1:0]  OUT_SPAN_RST  = DUTY_BITS'(255);
	localparam logic [DUTY_BITS-1:0]  DEAD_ZONE_RST = DUTY_BITS'(20);

	localparam logic [3:0] DIR_LF = 4'b0001;
	localparam logic [3:0] DIR_LR = 4'b0010;
	localparam logic [3:0] DIR_RF = 4'b0100;
	localparam logic [3:0] DIR_RR = 4'b1000;

	typedef enum logic [1:0] {
		REG_PULSE_MIN = 2'd0,
		REG_PULSE_MAX = 2'd1,
		REG_OUT_SPAN  = 2'd2,
		REG_DEAD_ZONE = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		LANE_IDLE,
		LANE_MUL,
		LANE_DIV,
		LANE_DONE
	} lane_state_t;

	typedef enum logic {
		TOP_IDLE,
		TOP_BUSY
	} top_state_t;

	typedef struct packed {
		logic                      done;
		logic signed [COORD_W-1:0] coord;
	} lane_res_t;

	function automatic logic [DUTY_BITS-1:0] mag_duty(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] a;
		a = (v < 0) ? -v : v;
		return a[DUTY_BITS-1:0];
	endfunction

endpackage

// ===== rtl/core/joystick_tank_drive_mixer.sv =====
// a new word is accepted only while idle, after the previous result has been
// loaded into the output register, so the axis lanes work on one word at a time
// each axis lane runs the word through a 25-step shift-subtract divider
// reset: registers return to their defaults, held duties and bridge bits clear
// ----------------------------------------------------------------------------
// joystick_tank_drive_mixer
// maps two stick pulse widths to tank drive duties and bridge direction bits,
// one divider lane per axis and a merging mixer stage
// ----------------------------------------------------------------------------
module joystick_tank_drive_mixer
	import jtdm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [DATA_W-1:0]     pwdata,
	output logic [DATA_W-1:0]     prdata,
	output logic                  pready,

	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PULSE_BITS-1:0] pulse_x,
	input  logic [PULSE_BITS-1:0] pulse_y,

	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [DUTY_BITS-1:0]  left_duty,
	output logic [DUTY_BITS-1:0]  right_duty,
	output logic                  left_fwd,
	output logic                  left_rev,
	output logic                  right_fwd,
	output logic                  right_rev
);

	logic [PULSE_BITS-1:0] pulse_min_q;
	logic [PULSE_BITS-1:0] pulse_max_q;
	logic [DUTY_BITS-1:0]  out_span_q;
	logic [DUTY_BITS-1:0]  dead_zone_q;
	reg_idx_t              reg_idx;

	top_state_t            state_q, state_nxt;
	logic                  start;
	logic                  load;
	logic                  out_free;
	lane_res_t             x_res, y_res;

	logic [DUTY_BITS-1:0]  nxt_left, nxt_right;
	logic [3:0]            nxt_dir;
	logic                  out_valid_q;
	logic [DUTY_BITS-1:0]  left_duty_q, right_duty_q;
	logic [3:0]            dir_q;

	// register file
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_min_q <= PULSE_MIN_RST;
			pulse_max_q <= PULSE_MAX_RST;
			out_span_q  <= OUT_SPAN_RST;
			dead_zone_q <= DEAD_ZONE_RST;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_PULSE_MIN: pulse_min_q <= pwdata[PULSE_BITS-1:0];
				REG_PULSE_MAX: pulse_max_q <= pwdata[PULSE_BITS-1:0];
				REG_OUT_SPAN:  out_span_q  <= pwdata[DUTY_BITS-1:0];
				REG_DEAD_ZONE: dead_zone_q <= pwdata[DUTY_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PULSE_MIN: prdata = DATA_W'(pulse_min_q);
			REG_PULSE_MAX: prdata = DATA_W'(pulse_max_q);
			REG_OUT_SPAN:  prdata = DATA_W'(out_span_q);
			REG_DEAD_ZONE: prdata = DATA_W'(dead_zone_q);
			default:       prdata = '0;
		endcase
	end

	// control
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TOP_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		start     = 1'b0;
		load      = 1'b0;
		in_stall  = 1'b1;
		case (state_q)
			TOP_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					start     = 1'b1;
					state_nxt = TOP_BUSY;
				end
			end
			TOP_BUSY: begin
				if (x_res.done && y_res.done && out_free) begin
					load      = 1'b1;
					state_nxt = TOP_IDLE;
				end
			end
			default: begin
				state_nxt = TOP_IDLE;
			end
		endcase
	end

	jtdm_lane u_lane_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.pulse     (pulse_x),
		.pulse_min (pulse_min_q),
		.pulse_max (pulse_max_q),
		.out_span  (out_span_q),
		.res       (x_res)
	);

	jtdm_lane u_lane_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.pulse     (pulse_y),
		.pulse_min (pulse_min_q),
		.pulse_max (pulse_max_q),
		.out_span  (out_span_q),
		.res       (y_res)
	);

	jtdm_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.x         (x_res.coord),
		.y         (y_res.coord),
		.dead_zone (dead_zone_q),
		.nxt_left  (nxt_left),
		.nxt_right (nxt_right),
		.nxt_dir   (nxt_dir)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			left_duty_q  <= nxt_left;
			right_duty_q <= nxt_right;
			dir_q        <= nxt_dir;
		end
	end

	assign out_valid  = out_valid_q;
	assign left_duty  = left_duty_q;
	assign right_duty = right_duty_q;
	assign left_fwd   = dir_q[0];
	assign left_rev   = dir_q[1];
	assign right_fwd  = dir_q[2];
	assign right_rev  = dir_q[3];

	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		x_res.done == y_res.done)
		else $error("axis lanes out of step");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == TOP_BUSY && !x_res.done))
		else $error("accepted word did not start the lanes");

	a_merge_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == TOP_BUSY && x_res.done && y_res.done && out_free)
		|=> (out_valid_q && state_q == TOP_IDLE))
		else $error("finished word not loaded into the output register");

endmodule

// ===== rtl/core/jtdm_lane.sv =====
// ----------------------------------------------------------------------------
// jtdm_lane
// one axis: clamps the pulse width, scales its offset by twice the span and
// divides by the pulse range (shift-subtract), one quotient bit a cycle
// ----------------------------------------------------------------------------
module jtdm_lane
	import jtdm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [PULSE_BITS-1:0] pulse,
	input  logic [PULSE_BITS-1:0] pulse_min,
	input  logic [PULSE_BITS-1:0] pulse_max,
	input  logic [DUTY_BITS-1:0]  out_span,
	output lane_res_t             res
);

	lane_state_t           state_q, state_nxt;
	logic [CNT_W-1:0]      cnt_q;
	logic [PULSE_BITS-1:0] diff_q;
	logic [PULSE_BITS-1:0] den_q;
	logic                  empty_q;
	logic [PROD_W-1:0]     work_q;
	logic [PULSE_BITS-1:0] rem_q;

	logic [PULSE_BITS-1:0] pulse_c;
	logic [PULSE_BITS:0]   trial;
	logic [PULSE_BITS:0]   sub;
	logic                  ge;
	logic [QUOT_W-1:0]     quot;
	logic [COORD_W-1:0]    coord_u;

	always_comb begin
		if (pulse < pulse_min) begin
			pulse_c = pulse_min;
		end else if (pulse > pulse_max) begin
			pulse_c = pulse_max;
		end else begin
			pulse_c = pulse;
		end
	end

	assign trial = {rem_q, work_q[PROD_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign sub   = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LANE_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			LANE_IDLE: begin
				if (start) state_nxt = LANE_MUL;
			end
			LANE_MUL: begin
				state_nxt = LANE_DIV;
			end
			LANE_DIV: begin
				if (cnt_q == CNT_W'(1)) state_nxt = LANE_DONE;
			end
			LANE_DONE: begin
				if (start) state_nxt = LANE_MUL;
			end
			default: begin
				state_nxt = LANE_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (start) begin
			diff_q  <= pulse_c - pulse_min;
			den_q   <= pulse_max - pulse_min;
			empty_q <= pulse_max <= pulse_min;
		end
		case (state_q)
			LANE_MUL: begin
				work_q <= PROD_W'(diff_q) * PROD_W'({out_span, 1'b0});
				rem_q  <= '0;
				cnt_q  <= CNT_W'(PROD_W);
			end
			LANE_DIV: begin
				rem_q  <= ge ? sub[PULSE_BITS-1:0] : trial[PULSE_BITS-1:0];
				work_q <= {work_q[PROD_W-2:0], ge};
				cnt_q  <= cnt_q - CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	assign quot    = work_q[QUOT_W-1:0];
	assign coord_u = {1'b0, quot} - {2'b00, out_span};

	assign res.done  = state_q == LANE_DONE;
	assign res.coord = empty_q ? '0 : signed'(coord_u);

	// quotient never exceeds twice the span because the pulse is clamped
	a_quot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == LANE_DONE && $past(state_q) == LANE_DIV && !empty_q)
		|-> (quot <= {out_span, 1'b0}))
		else $error("lane quotient out of range");

endmodule

// ===== rtl/core/jtdm_mix.sv =====
// ----------------------------------------------------------------------------
// jtdm_mix
// merges the two axis coordinates: deadband, octant rules and held outputs
// ----------------------------------------------------------------------------
module jtdm_mix
	import jtdm_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  logic signed [COORD_W-1:0] x,
	input  logic signed [COORD_W-1:0] y,
	input  logic [DUTY_BITS-1:0]      dead_zone,
	output logic [DUTY_BITS-1:0]      nxt_left,
	output logic [DUTY_BITS-1:0]      nxt_right,
	output logic [3:0]                nxt_dir
);

	logic [DUTY_BITS-1:0] held_left_q;
	logic [DUTY_BITS-1:0] held_right_q;
	logic [3:0]           held_dir_q;

	logic signed [SUM_W-1:0]   xs, ys, l, r;
	logic signed [COORD_W-1:0] ax, ay, dz;
	logic [3:0]                dir;
	logic                      upd;

	always_comb begin
		xs  = x;
		ys  = y;
		ax  = (x < 0) ? -x : x;
		ay  = (y < 0) ? -y : y;
		dz  = signed'({2'b00, dead_zone});
		l   = '0;
		r   = '0;
		dir = '0;
		upd = 1'b1;
		if (ax < dz && ay < dz) begin
			upd = 1'b1;
		end else if (xs < 0 && ys < 0) begin
			if (xs >= ys) begin
				l   = ys - xs;
				r   = ys;
				dir = DIR_LR | DIR_RR;
			end else begin
				l   = xs - ys;
				r   = ys - xs;
				dir = DIR_LR | DIR_RF;
			end
		end else if (xs < 0 && ys > 0) begin
			if (ys >= -xs) begin
				l   = ys + xs;
				r   = ys;
				dir = DIR_LF | DIR_RF;
			end else begin
				l   = ys + xs;
				r   = -xs;
				dir = DIR_LR | DIR_RF;
			end
		end else if (xs > 0 && ys < 0) begin
			if (-ys >= xs) begin
				l   = ys;
				r   = ys + xs;
				dir = DIR_LR | DIR_RR;
			end else begin
				l   = xs + ys;
				r   = xs + ys;
				dir = DIR_LF | DIR_RR;
			end
		end else if (xs > 0 && ys > 0) begin
			if (ys >= xs) begin
				l   = ys;
				r   = ys - xs;
				dir = DIR_LF | DIR_RF;
			end else begin
				l   = xs;
				r   = xs - ys;
				dir = DIR_LF | DIR_RR;
			end
		end else begin
			upd = 1'b0;
		end
		nxt_left  = upd ? mag_duty(l) : held_left_q;
		nxt_right = upd ? mag_duty(r) : held_right_q;
		nxt_dir   = upd ? dir : held_dir_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_left_q  <= '0;
			held_right_q <= '0;
			held_dir_q   <= '0;
		end else if (load) begin
			held_left_q  <= nxt_left;
			held_right_q <= nxt_right;
			held_dir_q   <= nxt_dir;
		end
	end

	// a bridge side is never driven forward and reverse at once
	a_no_shoot: assert property (@(posedge clk) disable iff (!arst_n)
		!((held_dir_q & (DIR_LF | DIR_LR)) == (DIR_LF | DIR_LR))
		&& !((held_dir_q & (DIR_RF | DIR_RR)) == (DIR_RF | DIR_RR)))
		else $error("bridge side driven both ways");

endmodule

// ===== tb/sv/joystick_tank_drive_mixer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// joystick_tank_drive_mixer_tb
// drives stick pulse words through the mixer under random idling and stalls,
// predicts duties and bridge bits from its own copy of the registers and held
// outputs, and checks every result word in order across several register
// settings, reversed and empty spans among them
// ----------------------------------------------------------------------------
module joystick_tank_drive_mixer_tb;
	import jtdm_pkg::*;

	typedef struct packed {
		logic [PULSE_BITS-1:0] x;
		logic [PULSE_BITS-1:0] y;
	} stick_word_t;

	typedef struct packed {
		logic [DUTY_BITS-1:0] left_duty;
		logic [DUTY_BITS-1:0] right_duty;
		logic [3:0]           dir;
	} drive_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [ADDR_W-1:0]     paddr = '0;
	logic [DATA_W-1:0]     pwdata = '0;
	logic [DATA_W-1:0]     prdata;
	logic                  pready;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [PULSE_BITS-1:0] pulse_x = '0;
	logic [PULSE_BITS-1:0] pulse_y = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [DUTY_BITS-1:0]  left_duty;
	logic [DUTY_BITS-1:0]  right_duty;
	logic                  left_fwd;
	logic                  left_rev;
	logic                  right_fwd;
	logic                  right_rev;

	stick_word_t stick_q[$];
	drive_t      drive_q[$];
	stick_word_t next_word;
	drive_t      held = '0;
	drive_t      got;

	int cfg_lo   = PULSE_MIN_RST;
	int cfg_hi   = PULSE_MAX_RST;
	int cfg_span = OUT_SPAN_RST;
	int cfg_dead = DEAD_ZONE_RST;

	int idle_pct = 35;
	int stall_pct = 35;
	bit send_hold = 1'b0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	bit in_fire = 1'b0;
	int mismatch_cnt = 0;

	joystick_tank_drive_mixer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pulse_x    (pulse_x),
		.pulse_y    (pulse_y),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.left_duty  (left_duty),
		.right_duty (right_duty),
		.left_fwd   (left_fwd),
		.left_rev   (left_rev),
		.right_fwd  (right_fwd),
		.right_rev  (right_rev)
	);

	always #5 clk = ~clk;

	function automatic int abs_i(int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic int axis_coord(logic [PULSE_BITS-1:0] p);
		longint v;
		longint q;
		if (cfg_hi <= cfg_lo)
			return 0;
		v = p;
		if (v < cfg_lo)
			v = cfg_lo;
		if (v > cfg_hi)
			v = cfg_hi;
		q = ((v - cfg_lo) * (2 * longint'(cfg_span))) / (cfg_hi - cfg_lo);
		return int'(q) - cfg_span;
	endfunction

	function automatic drive_t drive_of(int l, int r, logic [3:0] dir);
		drive_t d;
		d.left_duty  = DUTY_BITS'(abs_i(l));
		d.right_duty = DUTY_BITS'(abs_i(r));
		d.dir        = dir;
		return d;
	endfunction

	// zero coordinate outside the deadband keeps the previous drive
	function automatic drive_t mix_drive(int x, int y, drive_t prev);
		drive_t d;
		d = prev;
		if (abs_i(x) < cfg_dead && abs_i(y) < cfg_dead) begin
			d = '0;
		end else if (x < 0 && y < 0) begin
			if (x >= y)
				d = drive_of(y - x, y, DIR_LR | DIR_RR);
			else
				d = drive_of(x - y, y - x, DIR_LR | DIR_RF);
		end else if (x < 0 && y > 0) begin
			if (y >= -x)
				d = drive_of(y + x, y, DIR_LF | DIR_RF);
			else
				d = drive_of(y + x, -x, DIR_LR | DIR_RF);
		end else if (x > 0 && y < 0) begin
			if (-y >= x)
				d = drive_of(y, y + x, DIR_LR | DIR_RR);
			else
				d = drive_of(x + y, x + y, DIR_LF | DIR_RR);
		end else if (x > 0 && y > 0) begin
			if (y >= x)
				d = drive_of(y, y - x, DIR_LF | DIR_RF);
			else
				d = drive_of(x, x - y, DIR_LF | DIR_RR);
		end
		return d;
	endfunction

	function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
			mismatch_cnt++;
		end
	endfunction

	function automatic logic [PULSE_BITS-1:0] pick_pulse();
		int lo;
		int hi;
		int mid;
		lo = (cfg_lo < cfg_hi) ? cfg_lo : cfg_hi;
		hi = (cfg_lo < cfg_hi) ? cfg_hi : cfg_lo;
		mid = lo + (hi - lo) / 2;
		case ($urandom_range(9))
			0: return PULSE_BITS'($urandom);
			1: return PULSE_BITS'(lo - int'($urandom_range(3)));
			2: return PULSE_BITS'(hi + int'($urandom_range(3)));
			3: return PULSE_BITS'(mid + int'($urandom_range(2)) - 1);
			default: return PULSE_BITS'($urandom_range(hi, lo));
		endcase
	endfunction

	// word driver
	always @(negedge clk) begin
		if (in_fire || !in_valid) begin
			if (stick_q.size() != 0 && !send_hold && $urandom_range(99) >= idle_pct) begin
				next_word = stick_q.pop_front();
				in_valid <= 1'b1;
				pulse_x  <= next_word.x;
				pulse_y  <= next_word.y;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = 300;
		end
		if (hold_left > 0)
			hold_left--;
		out_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
	end

	// predict on input words, check output words
	always @(posedge clk) begin
		in_fire = in_valid && !in_stall;
		if (in_fire) begin
			held = mix_drive(axis_coord(pulse_x), axis_coord(pulse_y), held);
			drive_q.push_back(held);
		end
		if (out_valid && !out_stall) begin
			if (drive_q.size() == 0) begin
				$error("result word with no expected word pending");
				mismatch_cnt++;
			end else begin
				got = drive_q.pop_front();
				check_field("left_duty", got.left_duty, left_duty);
				check_field("right_duty", got.right_duty, right_duty);
				check_field("left_fwd", |(got.dir & DIR_LF), left_fwd);
				check_field("left_rev", |(got.dir & DIR_LR), left_rev);
				check_field("right_fwd", |(got.dir & DIR_RF), right_fwd);
				check_field("right_rev", |(got.dir & DIR_RR), right_rev);
			end
		end
	end

	task automatic reg_write(reg_idx_t idx, logic [DATA_W-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_PULSE_MIN: cfg_lo = val[PULSE_BITS-1:0];
			REG_PULSE_MAX: cfg_hi = val[PULSE_BITS-1:0];
			REG_OUT_SPAN:  cfg_span = val[7:0];
			REG_DEAD_ZONE: cfg_dead = val[7:0];
			default: begin
			end
		endcase
	endtask

	task automatic set_span(int lo, int hi, int span, int dead);
		reg_write(REG_PULSE_MIN, DATA_W'(lo));
		reg_write(REG_PULSE_MAX, DATA_W'(hi));
		reg_write(REG_OUT_SPAN, DATA_W'(span));
		reg_write(REG_DEAD_ZONE, DATA_W'(dead));
	endtask

	task automatic push_word(int x, int y);
		stick_q.push_back('{x: PULSE_BITS'(x), y: PULSE_BITS'(y)});
	endtask

	task automatic wait_drained();
		while (stick_q.size() != 0 || in_valid || drive_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic run_random(int n);
		@(posedge clk);
		repeat (n)
			push_word(pick_pulse(), pick_pulse());
		wait_drained();
	endtask

	initial begin
		int lo;
		int hi;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// defaults: deadband, saturation, every octant, hold and deadband edges
		@(posedge clk);
		push_word(1500, 1500);
		push_word(0, 0);
		push_word(65535, 65535);
		push_word(1000, 1000);
		push_word(1200, 1000);
		push_word(1000, 1200);
		push_word(1000, 2000);
		push_word(1000, 1800);
		push_word(2000, 1000);
		push_word(2000, 1200);
		push_word(2000, 2000);
		push_word(1800, 2000);
		push_word(2000, 1800);
		push_word(1500, 2000);
		push_word(2000, 1500);
		push_word(1539, 1500);
		push_word(1540, 1500);
		push_word(1540, 1540);
		push_word(1460, 1460);
		push_word(999, 2001);
		push_word(0, 65535);
		push_word(65535, 0);
		wait_drained();

		run_random(400);

		// full span, no deadband, no idling, long receiver hold up front
		set_span(0, 65535, 255, 0);
		@(posedge clk);
		idle_pct = 0;
		stall_pct = 0;
		hold_req++;
		run_random(200);
		idle_pct = 35;
		stall_pct = 35;

		// reversed and empty spans
		set_span(65535, 0, 255, 0);
		run_random(20);
		set_span(1234, 1234, 100, 0);
		run_random(20);
		set_span(2000, 1000, 255, 255);
		run_random(10);

		set_span(1000, 2000, 1, 1);
		run_random(100);
		set_span(1000, 2000, 0, 0);
		run_random(20);
		set_span(0, 1, 255, 255);
		run_random(50);

		for (int ph = 0; ph < 7; ph++) begin
			if ($urandom_range(3) == 0) begin
				lo = $urandom_range(65535);
				hi = $urandom_range(65535);
			end else begin
				lo = $urandom_range(3000);
				hi = lo + $urandom_range(3000, 1);
			end
			case ($urandom_range(3))
				0: set_span(lo, hi, 255, $urandom_range(40));
				1: set_span(lo, hi, $urandom_range(255, 1), $urandom_range(255));
				default: set_span(lo, hi, $urandom_range(255, 1), $urandom_range(40));
			endcase
			if (ph == 2) begin
				@(posedge clk);
				repeat (180)
					push_word(pick_pulse(), pick_pulse());
				while (stick_q.size() > 90)
					@(posedge clk);
				send_hold = 1'b1;
				while (in_valid || drive_q.size() != 0)
					@(posedge clk);
				@(posedge clk);
				send_hold = 1'b0;
				wait_drained();
			end else begin
				run_random(180);
			end
		end

		if (mismatch_cnt == 0 && drive_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
